// File: hw/rtl/rdc_pkg.sv
// Shared types and constants for the range dyadic cover block.
// No dependencies; used by every module of the block.
package rdc_pkg;

    localparam int MAX_LEVELS_DEF = 16;
    localparam int VAL_W          = 16;
    localparam int LEVEL_W        = 4;
    localparam int CFG_W          = 5;
    localparam logic [CFG_W-1:0] LEVELS_RST = 5'd16;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [VAL_W-1:0] range_low;
        logic [VAL_W-1:0] range_high;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               left_valid;
        logic [VAL_W-1:0]   left_node;
        logic               right_valid;
        logic [VAL_W-1:0]   right_node;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] range_low;
        logic [VAL_W-1:0] range_high;
        logic [CFG_W-1:0] depth;
    } cmd_t;

endpackage

// File: hw/rtl/rdc_front.sv
// Front end: levels register, request intake and the command queue.
// Depends on rdc_pkg.
module rdc_front #(
    parameter int MAX_LEVELS = rdc_pkg::MAX_LEVELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  rdc_pkg::in_item_t         item,
    input  logic                      cfg_we,
    input  logic [rdc_pkg::CFG_W-1:0] cfg_data,
    output logic                      cmd_valid,
    output rdc_pkg::cmd_t             cmd,
    input  logic                      cmd_pop
);

    logic [rdc_pkg::CFG_W-1:0] levels_reg;
    logic [rdc_pkg::CFG_W-1:0] depth;
    rdc_pkg::cmd_t             q_mem [rdc_pkg::Q_DEPTH];
    logic [rdc_pkg::Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rdc_pkg::Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rdc_pkg::Q_AW:0]    count_reg, count_next;
    logic                      accept;
    logic                      q_wr;
    logic                      q_rd;

    always_comb
    begin
        if (levels_reg > rdc_pkg::CFG_W'(MAX_LEVELS))
        begin
            depth = rdc_pkg::CFG_W'(MAX_LEVELS);
        end
        else
        begin
            depth = levels_reg;
        end
    end

    assign full      = (count_reg == (rdc_pkg::Q_AW+1)'(rdc_pkg::Q_DEPTH));
    assign accept    = push && !full;
    // zero-level requests produce nothing and are dropped here
    assign q_wr      = accept && (depth != '0);
    assign cmd_valid = (count_reg != '0);
    assign q_rd      = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_wr && !q_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!q_wr && q_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= rdc_pkg::LEVELS_RST;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
        begin
            q_mem[wr_ptr_reg] <= '{range_low:  item.range_low,
                                   range_high: item.range_high,
                                   depth:      depth};
        end
    end

endmodule

// File: hw/rtl/rdc_back.sv
// Back end: per-level tree walker and the result queue.
// Depends on rdc_pkg.
module rdc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  rdc_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output rdc_pkg::out_item_t  result
);

    localparam int VW = rdc_pkg::VAL_W;

    logic                        busy_reg, busy_next;
    logic [rdc_pkg::LEVEL_W-1:0] k_reg, k_next;
    logic                        dead_reg, dead_next;
    logic [rdc_pkg::CFG_W-1:0]   depth_reg;
    logic [VW-1:0]               lo_reg, hi_reg;
    logic [VW-1:0]               tl_reg, tl_next;
    logic [VW-1:0]               tr_reg, tr_next;

    rdc_pkg::out_item_t          q_mem [rdc_pkg::Q_DEPTH];
    logic [rdc_pkg::Q_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [rdc_pkg::Q_AW:0]      count_reg, count_next;

    logic          q_full;
    logic          pop_acc;
    logic          step;
    logic          is_last;
    logic [2*VW:0] last_leaf;
    logic [2*VW:0] first_leaf;
    logic          take_l, take_r;
    logic          load;
    rdc_pkg::out_item_t res;

    assign q_full  = (count_reg == (rdc_pkg::Q_AW+1)'(rdc_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_acc = pop && !empty;
    assign result  = q_mem[rd_ptr_reg];

    assign step    = busy_reg && (!q_full || pop_acc);
    assign is_last = ((rdc_pkg::CFG_W'(k_reg) + 1'b1) == depth_reg);
    assign load    = cmd_valid && (!busy_reg || (step && is_last));
    assign cmd_pop = load;

    assign last_leaf  = (((2*VW+1)'(tl_reg) + 1'b1) << k_reg) - 1'b1;
    assign first_leaf = (2*VW+1)'(tr_reg) << k_reg;
    assign take_l     = tl_reg[0] && (last_leaf <= (2*VW+1)'(hi_reg));
    // a wrapped right tracker stays odd and is never taken again
    assign take_r     = !dead_reg && !tr_reg[0] && (first_leaf >= (2*VW+1)'(lo_reg));

    always_comb
    begin
        res.level       = k_reg;
        res.left_valid  = take_l;
        res.left_node   = take_l ? tl_reg : '0;
        res.right_valid = take_r;
        res.right_node  = take_r ? tr_reg : '0;
        res.last        = is_last;
    end

    always_comb
    begin
        tl_next   = take_l ? (tl_reg >> 1) + 1'b1 : tl_reg >> 1;
        tr_next   = take_r ? (tr_reg >> 1) - 1'b1 : tr_reg >> 1;
        dead_next = dead_reg || (take_r && (tr_reg == '0));
        busy_next = busy_reg;
        k_next    = k_reg;
        if (step)
        begin
            k_next = k_reg + 1'b1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            dead_next = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (step && !pop_acc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!step && pop_acc)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            dead_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            if (step || load)
            begin
                dead_reg <= dead_next;
            end
            if (step)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg    <= cmd.range_low;
            hi_reg    <= cmd.range_high;
            depth_reg <= cmd.depth;
            tl_reg    <= cmd.range_low;
            tr_reg    <= cmd.range_high;
        end
        else if (step)
        begin
            tl_reg <= tl_next;
            tr_reg <= tr_next;
        end
        if (step)
        begin
            q_mem[wr_ptr_reg] <= res;
        end
    end

endmodule

// File: hw/rtl/range_dyadic_cover.sv
// Flow: a request passes the command queue and the walker registers to the result queue.
// Throughput: one result (one tree level) per cycle while the result queue has room or
// is popped; a request gives levels results (16 by default), zero-level ones none.
// Reset: asynchronous, active low; levels returns to 16 and both queues empty.
// Top level; instantiates rdc_front and rdc_back, uses rdc_pkg.
module range_dyadic_cover #(
    parameter int MAX_LEVELS = rdc_pkg::MAX_LEVELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  rdc_pkg::in_item_t         item,
    output logic                      empty,
    input  logic                      pop,
    output rdc_pkg::out_item_t        result,
    input  logic                      cfg_we,
    input  logic [rdc_pkg::CFG_W-1:0] cfg_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    rdc_pkg::cmd_t cmd;

    rdc_front #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    rdc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// File: hw/rtl/rdc_checker.sv
// Port-level checks for range_dyadic_cover, bound to the top level.
// Depends on rdc_pkg.
module rdc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input rdc_pkg::out_item_t result
);

    logic [rdc_pkg::LEVEL_W-1:0] exp_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_level_reg <= '0;
        end
        else if (pop && !empty)
        begin
            exp_level_reg <= result.last ? '0 : result.level + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not empty during reset");

    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.level == exp_level_reg)
        else $error("result level out of sequence");

    a_node_parity: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!result.left_valid || result.left_node[0])
                && (result.right_valid || result.right_node == '0)
                && (!result.right_valid || !result.right_node[0]))
        else $error("cover node parity or zero fill wrong");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

endmodule

bind range_dyadic_cover rdc_checker u_rdc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .result(result)
);
